// File: rtl/tsb_pkg.sv
// tsb_pkg: shared types, constants and helper functions of the textured span blender
// no dependencies; imported by every module under rtl
package tsb_pkg;

   // field and datapath widths
   localparam int COORD_W    = 32;
   localparam int SIZE_W     = 13;
   localparam int HI_W       = 16;
   localparam int FRAC_W     = 16;
   localparam int FACTOR_W   = 9;
   localparam int CHAN_W     = 8;
   localparam int PIX_W      = 32;
   localparam int ROW_PROD_W = 2 * SIZE_W;
   localparam int ADDR_SUM_W = 2 * SIZE_W + 1;
   localparam int IDX_W      = 12;
   localparam int CMD_W      = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int REQ_DATA_W = 272;
   localparam int CNT_W      = 5;
   localparam int NUM_CHAN   = 4;

   // channel order r, g, b, a and their bit positions in AARRGGBB
   localparam int CHAN_A = 3;
   localparam int CHAN_POS [NUM_CHAN] = '{16, 8, 0, 24};

   localparam logic [FACTOR_W-1:0] FACTOR_ONE     = 9'h100;
   localparam logic [CHAN_W-1:0]   BLEND_ROUND    = 8'h7f;
   localparam logic [SIZE_W-1:0]   TEX_SIZE_RESET = 13'd64;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_TEXEL = 2'd0,
      CMD_LOAD_START = 2'd1,
      CMD_LOAD_SLOPE = 2'd2,
      CMD_RENDER     = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TEX_WIDTH  = 1'b0,
      REG_TEX_HEIGHT = 1'b1
   } csr_reg_type;

   typedef logic [FACTOR_W-1:0] factor_type;
   typedef logic [CHAN_W-1:0]   chan_type;

   // status of one coordinate wrap unit
   typedef struct packed {
      logic              busy;
      logic [SIZE_W-1:0] value;
   } wrap_stat_type;

   // color factor: acc>>8, negative gives zero, capped at one
   function automatic factor_type factor_of(input logic [COORD_W-1:0] acc);
      logic [22:0] f;
      f = acc[30:8];
      if (acc[31]) begin
         return '0;
      end else if (f > 23'(FACTOR_ONE)) begin
         return FACTOR_ONE;
      end else begin
         return f[FACTOR_W-1:0];
      end
   endfunction

   // a texture size of zero behaves as one
   function automatic logic [SIZE_W-1:0] size_eff(input logic [SIZE_W-1:0] s);
      return (s == '0) ? SIZE_W'(1) : s;
   endfunction

endpackage

// File: rtl/textured_span_blender.sv
// textured_span_blender: top level, command decode, interpolators and render sequence
// depends on tsb_pkg, tsb_wrap, tsb_tex_ram, tsb_shade
//
// Usage: items arrive on req_* with the command in req_tuser. Texel loads,
// span start loads and slope loads give no result. A render item gives one
// blended pixel on rsp_*. The texture size registers are written on csr_*
// (index 0 width, index 1 height); the user must write them only while no
// item is in work, which the block itself does not enforce. A render runs
// the bit-serial coordinate wrap (one quotient bit per cycle on the 16-bit
// integer part, then a state that sees it done), then the row multiply, the
// texture read (registered memory), modulation and blend. One item is in work
// at a time: a render closes the input, which reopens as its pixel enters the
// output register, while loads are taken one per cycle when no render is in work.
// The result sits in an output register: the next item is accepted while it
// waits, and a following render stalls only in its last stage until
// rsp_tready frees the register. Reset clears the interpolators, sets both
// texture sizes to 64 and empties the output; the texture store is not
// cleared and must be loaded before it is read.
module textured_span_blender #(
   parameter int TEX_WORDS = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata fields, low bit up: texel_index[12], texel_value[32],
   // dest_pixel[32], v_tx[32], v_ty[32], v_r[32], v_g[32], v_b[32], v_a[32], zero pad
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tsb_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [tsb_pkg::CMD_W-1:0]       req_tuser,   // cmd
   // rsp_tdata fields: out_pixel[32]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tsb_pkg::PIX_W-1:0]       rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tsb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tsb_pkg::SIZE_W-1:0]      csr_data
);
   import tsb_pkg::*;

   localparam int ADDR_W = (TEX_WORDS > 1) ? $clog2(TEX_WORDS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_WRAP, ST_ROW, ST_FETCH, ST_MOD, ST_OUT
   } state_type;

   // request fields
   logic [IDX_W-1:0]   req_index;
   logic [PIX_W-1:0]   req_texel;
   logic [PIX_W-1:0]   req_dest;
   logic [COORD_W-1:0] req_v [6];

   assign req_index = req_tdata[11:0];
   assign req_texel = req_tdata[43:12];
   assign req_dest  = req_tdata[75:44];
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         req_v[i] = req_tdata[76 + COORD_W*i +: COORD_W];
      end
   end

   state_type           state_ff, state_in;
   logic [SIZE_W-1:0]   tex_width_ff, tex_width_in;
   logic [SIZE_W-1:0]   tex_height_ff, tex_height_in;
   logic [COORD_W-1:0]  coord_u_ff, coord_u_in;
   logic [COORD_W-1:0]  coord_v_ff, coord_v_in;
   logic [COORD_W-1:0]  step_u_ff, step_u_in;
   logic [COORD_W-1:0]  step_v_ff, step_v_in;
   logic [COORD_W-1:0]  color_acc_ff [NUM_CHAN];
   logic [COORD_W-1:0]  color_acc_in [NUM_CHAN];
   logic [COORD_W-1:0]  color_step_ff [NUM_CHAN];
   logic [COORD_W-1:0]  color_step_in [NUM_CHAN];
   factor_type [NUM_CHAN-1:0] factor_ff, factor_in;
   logic [FRAC_W-1:0]   lo_u_ff, lo_u_in;
   logic [FRAC_W-1:0]   lo_v_ff, lo_v_in;
   logic [PIX_W-1:0]    dest_ff, dest_in;
   logic [ROW_PROD_W-1:0] row_prod_ff, row_prod_in;
   logic                in_range_ff, in_range_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [PIX_W-1:0]    rsp_tdata_ff, rsp_tdata_in;

   logic                accept;
   logic                render_start;
   logic [SIZE_W-1:0]   w_eff;
   logic [SIZE_W-1:0]   h_eff;
   logic [ADDR_SUM_W-1:0] addr_sum;
   logic                rsp_free;
   logic                tex_wr_en;
   logic [PIX_W-1:0]    tex_rd_data;
   logic [PIX_W-1:0]    texel;
   logic [PIX_W-1:0]    shaded;
   wrap_stat_type       wrap_u;
   wrap_stat_type       wrap_v;

   assign req_tready   = (state_ff == ST_IDLE);
   assign accept       = req_tvalid && req_tready;
   assign render_start = accept && (cmd_type'(req_tuser) == CMD_RENDER);
   assign csr_ready    = 1'b1;
   assign w_eff        = size_eff(tex_width_ff);
   assign h_eff        = size_eff(tex_height_ff);
   assign addr_sum     = ADDR_SUM_W'(row_prod_ff) + ADDR_SUM_W'(wrap_u.value);
   assign rsp_free     = !rsp_tvalid_ff || rsp_tready;
   assign tex_wr_en    = accept && (cmd_type'(req_tuser) == CMD_LOAD_TEXEL)
                         && (32'(req_index) < 32'(TEX_WORDS));
   assign texel        = in_range_ff ? tex_rd_data : '0;

   // coordinate wrap units
   tsb_wrap u_wrap_u (
      .clock    (clock),
      .reset    (reset),
      .start    (render_start),
      .coord_hi (coord_u_ff[COORD_W-1:FRAC_W]),
      .size     (w_eff),
      .stat     (wrap_u)
   );

   tsb_wrap u_wrap_v (
      .clock    (clock),
      .reset    (reset),
      .start    (render_start),
      .coord_hi (coord_v_ff[COORD_W-1:FRAC_W]),
      .size     (h_eff),
      .stat     (wrap_v)
   );

   // texture store; loads and reads never overlap since one item is in work
   tsb_tex_ram #(
      .DEPTH  (TEX_WORDS),
      .ADDR_W (ADDR_W)
   ) u_tex_ram (
      .clock   (clock),
      .wr_en   (tex_wr_en),
      .wr_addr (ADDR_W'(req_index)),
      .wr_data (req_texel),
      .rd_en   (state_ff == ST_FETCH),
      .rd_addr (ADDR_W'(addr_sum)),
      .rd_data (tex_rd_data)
   );

   // modulation and blend
   tsb_shade u_shade (
      .clock   (clock),
      .load    (state_ff == ST_MOD),
      .texel   (texel),
      .factors (factor_ff),
      .dest    (dest_ff),
      .pixel   (shaded)
   );

   // command decode and render sequence
   always_comb begin
      state_in      = state_ff;
      tex_width_in  = tex_width_ff;
      tex_height_in = tex_height_ff;
      coord_u_in    = coord_u_ff;
      coord_v_in    = coord_v_ff;
      step_u_in     = step_u_ff;
      step_v_in     = step_v_ff;
      color_acc_in  = color_acc_ff;
      color_step_in = color_step_ff;
      factor_in     = factor_ff;
      lo_u_in       = lo_u_ff;
      lo_v_in       = lo_v_ff;
      dest_in       = dest_ff;
      row_prod_in   = row_prod_ff;
      in_range_in   = in_range_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;

      // configuration writes
      if (csr_valid && csr_ready) begin
         case (csr_reg_type'(csr_index))
            REG_TEX_WIDTH:  tex_width_in  = csr_data;
            REG_TEX_HEIGHT: tex_height_in = csr_data;
            default: ;
         endcase
      end

      // output register drains
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (cmd_type'(req_tuser))
                  CMD_LOAD_START: begin
                     coord_u_in = req_v[0];
                     coord_v_in = req_v[1];
                     for (int i = 0; i < NUM_CHAN; i++) begin
                        color_acc_in[i] = req_v[2 + i];
                     end
                  end
                  CMD_LOAD_SLOPE: begin
                     step_u_in = req_v[0];
                     step_v_in = req_v[1];
                     for (int i = 0; i < NUM_CHAN; i++) begin
                        color_step_in[i] = req_v[2 + i];
                     end
                  end
                  CMD_RENDER: begin
                     lo_u_in = coord_u_ff[FRAC_W-1:0];
                     lo_v_in = coord_v_ff[FRAC_W-1:0];
                     dest_in = req_dest;
                     for (int i = 0; i < NUM_CHAN; i++) begin
                        factor_in[i] = factor_of(color_acc_ff[i]);
                     end
                     state_in = ST_WRAP;
                  end
                  default: ;
               endcase
            end
         end
         ST_WRAP: begin
            if (!wrap_u.busy && !wrap_v.busy) begin
               state_in = ST_ROW;
            end
         end
         ST_ROW: begin
            // row base and interpolator step from the wrapped coordinates
            row_prod_in = ROW_PROD_W'(wrap_v.value) * ROW_PROD_W'(w_eff);
            coord_u_in  = COORD_W'({wrap_u.value, lo_u_ff}) + step_u_ff;
            coord_v_in  = COORD_W'({wrap_v.value, lo_v_ff}) + step_v_ff;
            for (int i = 0; i < NUM_CHAN; i++) begin
               color_acc_in[i] = color_acc_ff[i] + color_step_ff[i];
            end
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            in_range_in = (32'(addr_sum) < 32'(TEX_WORDS));
            state_in    = ST_MOD;
         end
         ST_MOD: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = shaded;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tex_width_ff  <= TEX_SIZE_RESET;
         tex_height_ff <= TEX_SIZE_RESET;
         coord_u_ff    <= '0;
         coord_v_ff    <= '0;
         step_u_ff     <= '0;
         step_v_ff     <= '0;
         for (int i = 0; i < NUM_CHAN; i++) begin
            color_acc_ff[i]  <= '0;
            color_step_ff[i] <= '0;
         end
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tex_width_ff  <= tex_width_in;
         tex_height_ff <= tex_height_in;
         coord_u_ff    <= coord_u_in;
         coord_v_ff    <= coord_v_in;
         step_u_ff     <= step_u_in;
         step_v_ff     <= step_v_in;
         color_acc_ff  <= color_acc_in;
         color_step_ff <= color_step_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      factor_ff    <= factor_in;
      lo_u_ff      <= lo_u_in;
      lo_v_ff      <= lo_v_in;
      dest_ff      <= dest_in;
      row_prod_ff  <= row_prod_in;
      in_range_ff  <= in_range_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // a render item closes the input until its pixel is out
   a_render_blocks: assert property (@(posedge clock) disable iff (reset)
      render_start |=> !req_tready)
      else $error("input open while a render is in work");

   // wrapped coordinates lie inside the texture
   a_wrap_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROW) |-> (wrap_u.value < w_eff && wrap_v.value < h_eff))
      else $error("wrapped coordinate outside texture");

   // the last stage hands its pixel to a free output register
   a_out_handoff: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_free) |=> (rsp_tvalid && state_ff == ST_IDLE))
      else $error("pixel not delivered to output register");

endmodule

// File: rtl/tsb_wrap.sv
// tsb_wrap: iterative floor modulo of the integer part of a 16.16 coordinate
// by the texture size, one quotient bit per cycle; depends on tsb_pkg
module tsb_wrap (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [tsb_pkg::HI_W-1:0]   coord_hi,
   input  logic [tsb_pkg::SIZE_W-1:0]    size,
   output tsb_pkg::wrap_stat_type        stat
);
   import tsb_pkg::*;

   logic [HI_W-1:0]   mag_ff, mag_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SIZE_W:0]   trial;
   logic [SIZE_W:0]   diff;

   // restoring remainder step on the magnitude
   always_comb begin
      trial   = {rem_ff, mag_ff[HI_W-1]};
      diff    = trial - {1'b0, size_ff};
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      size_in = size_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         mag_in  = coord_hi[HI_W-1] ? HI_W'(-coord_hi) : HI_W'(coord_hi);
         rem_in  = '0;
         size_in = size;
         neg_in  = coord_hi[HI_W-1];
         cnt_in  = CNT_W'(HI_W);
      end else if (cnt_ff != '0) begin
         rem_in = (trial >= {1'b0, size_ff}) ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
         mag_in = {mag_ff[HI_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      mag_ff  <= mag_in;
      rem_ff  <= rem_in;
      size_ff <= size_in;
      neg_ff  <= neg_in;
   end

   // negative coordinates fold back into 0..size-1
   assign stat.busy  = (cnt_ff != '0);
   assign stat.value = (neg_ff && rem_ff != '0) ? size_ff - rem_ff : rem_ff;

endmodule

// File: rtl/tsb_tex_ram.sv
// tsb_tex_ram: texture store, one write port and one registered read port
// depends on tsb_pkg
module tsb_tex_ram #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [tsb_pkg::PIX_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [tsb_pkg::PIX_W-1:0] rd_data
);
   import tsb_pkg::*;

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/tsb_shade.sv
// tsb_shade: texel modulation by the color factors (registered) and alpha blend
// with the destination pixel; depends on tsb_pkg
module tsb_shade (
   input  logic                                      clock,
   input  logic                                      load,
   input  logic [tsb_pkg::PIX_W-1:0]                 texel,
   input  tsb_pkg::factor_type [tsb_pkg::NUM_CHAN-1:0] factors,
   input  logic [tsb_pkg::PIX_W-1:0]                 dest,
   output logic [tsb_pkg::PIX_W-1:0]                 pixel
);
   import tsb_pkg::*;

   chan_type s_ff [NUM_CHAN];
   chan_type s_in [NUM_CHAN];
   logic [16:0] prod [NUM_CHAN];

   // modulate: (channel * factor) >> 8
   always_comb begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         prod[i] = 17'(texel[CHAN_POS[i] +: CHAN_W]) * 17'(factors[i]);
         s_in[i] = load ? prod[i][15:8] : s_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         s_ff[i] <= s_in[i];
      end
   end

   // blend: (as*s + (256-as)*d + 127) >> 8
   logic [FACTOR_W-1:0] inv_a;
   logic [16:0]         mix [NUM_CHAN];

   always_comb begin
      inv_a = FACTOR_ONE - FACTOR_W'(s_ff[CHAN_A]);
      pixel = '0;
      for (int i = 0; i < NUM_CHAN; i++) begin
         mix[i] = 17'(s_ff[CHAN_A]) * 17'(s_ff[i])
                + 17'(inv_a) * 17'(dest[CHAN_POS[i] +: CHAN_W])
                + 17'(BLEND_ROUND);
         pixel[CHAN_POS[i] +: CHAN_W] = mix[i][15:8];
      end
   end

endmodule

// File: tb/sv/textured_span_blender_tb.sv
`timescale 1ns / 1ps
// textured_span_blender_tb: self-checking bench for the textured span blender, with a
// directed table and random span traffic checked against an in-bench pixel predictor
// depends on tsb_pkg and textured_span_blender
module textured_span_blender_tb;
   import tsb_pkg::*;

   localparam int TEX_WORDS     = 4096;
   localparam int SETTLE_CYCLES = 32;
   localparam int QUIET_LIMIT   = 4000;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 230;
   localparam int PIX_SHIFT [4] = '{16, 8, 0, 24};

   // one request item, fields as the block sees them
   typedef struct packed {
      cmd_type     cmd;
      logic [11:0] index;
      logic [31:0] texel;
      logic [31:0] dest;
      logic [31:0] tx;
      logic [31:0] ty;
      logic [31:0] r;
      logic [31:0] g;
      logic [31:0] b;
      logic [31:0] a;
   } span_cmd_type;

   // directed row: item plus an optional hand-computed pixel
   typedef struct packed {
      span_cmd_type item;
      logic         chk;
      logic [31:0]  pix;
   } dir_row_type;

   localparam int DIR_ROWS = 20;
   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      // after reset every factor is zero, so the destination comes back as is
      '{'{CMD_RENDER, 12'h000, 32'h0, 32'h12345678,
          32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, 32'h12345678},
      '{'{CMD_LOAD_TEXEL, 12'h000, 32'hffffffff, 32'h0,
          32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, 32'h0},
      '{'{CMD_LOAD_TEXEL, 12'hfff, 32'hffffffff, 32'h0,
          32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, 32'h0},
      '{'{CMD_LOAD_TEXEL, 12'h001, 32'h00000000, 32'h0,
          32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, 32'h0},
      // full factors on a white texel
      '{'{CMD_LOAD_START, 12'h000, 32'h0, 32'h0,
          32'h0, 32'h0, 32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000},
        1'b0, 32'h0},
      '{'{CMD_LOAD_SLOPE, 12'h000, 32'h0, 32'h0,
          32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, 32'h0},
      '{'{CMD_RENDER, 12'h000, 32'h0, 32'h00000000,
          32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, 32'hfefefefe},
      '{'{CMD_RENDER, 12'h000, 32'h0, 32'hffffffff,
          32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, 32'hffffffff},
      // factors saturate high, black texel at column one
      '{'{CMD_LOAD_START, 12'h000, 32'h0, 32'h0,
          32'h00010000, 32'h0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff},
        1'b0, 32'h0},
      '{'{CMD_RENDER, 12'h000, 32'h0, 32'h5a5aa5a5,
          32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, 32'h5a5aa5a5},
      // most negative coordinates wrap to zero, negative factors give zero
      '{'{CMD_LOAD_START, 12'h000, 32'h0, 32'h0,
          32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
          32'h80000000}, 1'b0, 32'h0},
      '{'{CMD_RENDER, 12'h000, 32'h0, 32'hc3c3c3c3,
          32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, 32'hc3c3c3c3},
      // last texel of a 64x64 texture
      '{'{CMD_LOAD_START, 12'h000, 32'h0, 32'h0,
          32'h003f0000, 32'h003f0000, 32'h00010000, 32'h00010000, 32'h00010000,
          32'h00010000}, 1'b0, 32'h0},
      '{'{CMD_RENDER, 12'h000, 32'h0, 32'h00000000,
          32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, 32'hfefefefe},
      // extreme slopes: coordinate and accumulator sums wrap
      '{'{CMD_LOAD_SLOPE, 12'h000, 32'h0, 32'h0,
          32'h7fffffff, 32'h80000000, 32'hffffff00, 32'h00000100, 32'h7fffffff,
          32'h80000000}, 1'b0, 32'h0},
      '{'{CMD_RENDER, 12'h000, 32'h0, 32'h00ff00ff,
          32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, 32'h0},
      '{'{CMD_RENDER, 12'h000, 32'h0, 32'hff00ff00,
          32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, 32'h0},
      '{'{CMD_RENDER, 12'h000, 32'h0, 32'h80808080,
          32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, 32'h0},
      // coordinate of minus one lands on the last column, half factors
      '{'{CMD_LOAD_START, 12'h000, 32'h0, 32'h0,
          32'hffffffff, 32'h00018000, 32'h00008000, 32'h00008000, 32'h00008000,
          32'h00008000}, 1'b0, 32'h0},
      '{'{CMD_RENDER, 12'h000, 32'h0, 32'h3c3c3c3c,
          32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, 32'h0}
   };

   // phase texture sizes: zero, one, beyond the store, long strips, small sizes; the last phase draws a random size
   localparam logic [12:0] PHASE_W [PHASES] = '{13'd0, 13'd1, 13'd8191, 13'd4096,
                                                13'd1, 13'd16, 13'd64, 13'd5};
   localparam logic [12:0] PHASE_H [PHASES] = '{13'd0, 13'd1, 13'd8191, 13'd1,
                                                13'd4096, 13'd8, 13'd64, 13'd3};
   localparam int SEND_IDLE [4] = '{0, 60, 0, 25};
   localparam int RECV_IDLE [4] = '{0, 0, 60, 25};

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic [CMD_W-1:0]       req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [PIX_W-1:0]       rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [SIZE_W-1:0]      csr_data   = '0;

   textured_span_blender #(.TEX_WORDS(TEX_WORDS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // predictor state
   logic [31:0] texels    [TEX_WORDS];
   bit          texel_set [TEX_WORDS];
   logic [31:0] coord_u, coord_v, u_step, v_step;
   logic [31:0] col_acc  [4];
   logic [31:0] col_step [4];
   logic [12:0] tex_w, tex_h;

   logic [31:0] pending_pixels [$];
   logic [31:0] want_pixel;
   int          error_count  = 0;
   int          issued_items = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          quiet_cycles  = 0;

   // wrap a 16.16 coordinate into [0, size*65536)
   function automatic logic [31:0] span_wrap(logic [31:0] c, logic [12:0] size);
      longint period;
      longint m;
      period = (size == 13'd0) ? 64'sd65536 : longint'(size) * 65536;
      m = longint'($signed(c)) % period;
      if (m < 0) begin
         m = m + period;
      end
      return m[31:0];
   endfunction

   // store address of the texel under wrapped coordinates
   function automatic longint fetch_addr(logic [31:0] u, logic [31:0] v);
      return longint'(v[31:16]) * longint'((tex_w == 13'd0) ? 13'd1 : tex_w)
             + longint'(u[31:16]);
   endfunction

   // color factor from an accumulator, held to 0..256
   function automatic int chan_factor(logic [31:0] acc);
      int f;
      if (acc[31]) begin
         return 0;
      end
      f = int'(acc >> 8);
      return (f > 256) ? 256 : f;
   endfunction

   // advance the predictor by one item, giving the blended pixel of a render
   function automatic void span_step(span_cmd_type it, output bit has_px,
                                     output logic [31:0] px);
      logic [31:0] u, v, texel;
      longint      addr;
      int          s [4];
      int          as, d, c;
      has_px = 1'b0;
      px     = '0;
      case (it.cmd)
         CMD_LOAD_TEXEL: begin
            texels[it.index]    = it.texel;
            texel_set[it.index] = 1'b1;
         end
         CMD_LOAD_START: begin
            coord_u = it.tx;
            coord_v = it.ty;
            col_acc = '{it.r, it.g, it.b, it.a};
         end
         CMD_LOAD_SLOPE: begin
            u_step   = it.tx;
            v_step   = it.ty;
            col_step = '{it.r, it.g, it.b, it.a};
         end
         default: begin
            u     = span_wrap(coord_u, tex_w);
            v     = span_wrap(coord_v, tex_h);
            addr  = fetch_addr(u, v);
            texel = (addr < TEX_WORDS) ? texels[int'(addr)] : 32'h0;
            for (int i = 0; i < 4; i++) begin
               s[i] = (int'((texel >> PIX_SHIFT[i]) & 32'hff) * chan_factor(col_acc[i])) >> 8;
            end
            as = s[3];
            for (int i = 0; i < 4; i++) begin
               d  = int'((it.dest >> PIX_SHIFT[i]) & 32'hff);
               c  = (as * s[i] + (256 - as) * d + 127) >> 8;
               px = px | (32'(c & 255) << PIX_SHIFT[i]);
            end
            coord_u = u + u_step;
            coord_v = v + v_step;
            for (int i = 0; i < 4; i++) begin
               col_acc[i] = col_acc[i] + col_step[i];
            end
            has_px = 1'b1;
         end
      endcase
   endfunction

   task automatic report_mismatch(string what);
      error_count++;
      if (error_count <= 60) begin
         $display("MISMATCH at %0t: %s", $time, what);
      end
   endtask

   // fully random item, the base of every generated one
   function automatic span_cmd_type rand_item();
      span_cmd_type it;
      it.cmd   = cmd_type'($urandom_range(3));
      it.index = 12'($urandom);
      it.texel = $urandom;
      it.dest  = $urandom;
      it.tx    = $urandom;
      it.ty    = $urandom;
      it.r     = $urandom;
      it.g     = $urandom;
      it.b     = $urandom;
      it.a     = $urandom;
      return it;
   endfunction

   function automatic logic [31:0] pick_factor();
      case ($urandom_range(2))
         0:       return $urandom_range(0, 32'h12000);
         1:       return $urandom_range(32'hf000, 32'h10200);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] small_slope(logic [31:0] span);
      if ($urandom_range(4) == 0) begin
         return '0;
      end
      return $urandom_range(0, 2 * span) - span;
   endfunction

   // drive one item and wait for it to be taken
   task automatic send_item(span_cmd_type it, logic chk, logic [31:0] pix);
      bit          has_px;
      logic [31:0] px;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.cmd;
      req_tdata  <= {4'b0, it.a, it.b, it.g, it.r, it.ty, it.tx, it.dest, it.texel,
                     it.index};
      do @(posedge clock); while (!req_tready);
      span_step(it, has_px, px);
      if (has_px) begin
         pending_pixels.push_back(chk ? pix : px);
      end
      issued_items++;
   endtask

   // a render that would fetch a never-written texel gets that texel loaded first
   task automatic issue(span_cmd_type it, logic chk, logic [31:0] pix);
      span_cmd_type fill;
      longint       addr;
      if (it.cmd == CMD_RENDER) begin
         addr = fetch_addr(span_wrap(coord_u, tex_w), span_wrap(coord_v, tex_h));
         if (addr < TEX_WORDS && !texel_set[int'(addr)]) begin
            fill       = rand_item();
            fill.cmd   = CMD_LOAD_TEXEL;
            fill.index = 12'(addr);
            send_item(fill, 1'b0, '0);
         end
      end
      send_item(it, chk, pix);
   endtask

   // let the block go idle: all pixels back, then a settling wait
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(csr_reg_type idx, logic [12:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_TEX_WIDTH) begin
         tex_w = val;
      end else begin
         tex_h = val;
      end
   endtask

   task automatic set_tex_size(logic [12:0] w, logic [12:0] h);
      drain();
      csr_put(REG_TEX_WIDTH, w);
      csr_put(REG_TEX_HEIGHT, h);
      csr_valid <= 1'b0;
   endtask

   // one span: optional texel, start and slope loads, then a run of pixels
   task automatic span_burst();
      span_cmd_type it;
      int           eff_w, eff_h, foot;
      eff_w = (tex_w == 13'd0) ? 1 : int'(tex_w);
      eff_h = (tex_h == 13'd0) ? 1 : int'(tex_h);
      foot  = (eff_w * eff_h > TEX_WORDS) ? TEX_WORDS : eff_w * eff_h;
      if ($urandom_range(99) < 30) begin
         repeat ($urandom_range(1, 6)) begin
            it       = rand_item();
            it.cmd   = CMD_LOAD_TEXEL;
            it.index = 12'($urandom_range(0, foot - 1));
            issue(it, 1'b0, '0);
         end
      end
      if ($urandom_range(99) < 90) begin
         it     = rand_item();
         it.cmd = CMD_LOAD_START;
         if ($urandom_range(99) < 70) begin
            it.tx = {16'($urandom_range(0, eff_w - 1)), 16'($urandom)};
            it.ty = {16'($urandom_range(0, eff_h - 1)), 16'($urandom)};
            it.r  = pick_factor();
            it.g  = pick_factor();
            it.b  = pick_factor();
            it.a  = pick_factor();
         end
         issue(it, 1'b0, '0);
      end
      if ($urandom_range(99) < 90) begin
         it     = rand_item();
         it.cmd = CMD_LOAD_SLOPE;
         if ($urandom_range(99) < 75) begin
            it.tx = small_slope(32'h30000);
            it.ty = small_slope(32'h30000);
            it.r  = small_slope(32'h1800);
            it.g  = small_slope(32'h1800);
            it.b  = small_slope(32'h1800);
            it.a  = small_slope(32'h1800);
         end
         issue(it, 1'b0, '0);
      end
      repeat ($urandom_range(1, 16)) begin
         it     = rand_item();
         it.cmd = CMD_RENDER;
         issue(it, 1'b0, '0);
      end
   endtask

   // receiver stalls
   always @(posedge clock) begin
      rsp_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
   end

   // pixel checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("out_pixel %08h with no pixel pending", rsp_tdata));
         end else begin
            want_pixel = pending_pixels.pop_front();
            if (rsp_tdata !== want_pixel) begin
               report_mismatch($sformatf("out_pixel %08h, predicted %08h",
                                         rsp_tdata, want_pixel));
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("textured_span_blender_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // main sequence
   initial begin
      int start_count;
      coord_u  = '0;
      coord_v  = '0;
      u_step   = '0;
      v_step   = '0;
      col_acc  = '{default: '0};
      col_step = '{default: '0};
      tex_w    = TEX_SIZE_RESET;
      tex_h    = TEX_SIZE_RESET;
      for (int i = 0; i < TEX_WORDS; i++) begin
         texels[i]    = '0;
         texel_set[i] = 1'b0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < DIR_ROWS; i++) begin
         issue(DIR_TABLE[i].item, DIR_TABLE[i].chk, DIR_TABLE[i].pix);
      end

      // random phases, each with its own texture size and idle pattern
      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES - 1) begin
            set_tex_size(13'($urandom_range(1, 300)), 13'($urandom_range(1, 300)));
         end else begin
            set_tex_size(PHASE_W[p], PHASE_H[p]);
         end
         send_idle_pct = SEND_IDLE[p % 4];
         recv_idle_pct = RECV_IDLE[p % 4];
         start_count   = issued_items;
         while (issued_items - start_count < PHASE_ITEMS) begin
            if ($urandom_range(99) < 15) begin
               issue(rand_item(), 1'b0, '0);
            end else begin
               span_burst();
            end
         end
      end

      drain();
      if (error_count == 0) begin
         $display("textured_span_blender_tb: clean");
      end else begin
         $display("textured_span_blender_tb: errors");
      end
      $finish;
   end

endmodule
